>>> rtl/core/assert_macros.svh
// Assertion helpers for the RTL; every user has i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Condition must never be seen at a clock edge out of reset.
`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

>>> rtl/core/tcpc_pkg.sv
package tcpc_pkg;

    // Parser phase within one packet
    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_DATA   = 2'd1,
        PH_PEC_HI = 2'd2,
        PH_PEC_LO = 2'd3
    } t_phase;

    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'h1021;
    localparam logic [15:0] LEN_OFFSET = 16'd5;

    // Header byte positions
    localparam logic [3:0] HDR_BYTES = 4'd10;
    localparam logic [3:0] HDR_LAST  = 4'd9;
    localparam logic [3:0] IDX_SEQ   = 4'd2;
    localparam logic [3:0] IDX_LEN   = 4'd4;
    localparam logic [3:0] IDX_DFH   = 4'd6;

    // One decoded packet
    typedef struct packed {
        logic [15:0] packet_ident;
        logic [10:0] app_id;
        logic [1:0]  seq_flags;
        logic [13:0] seq_count;
        logic [15:0] length_field;
        logic [3:0]  ack_bits;
        logic [7:0]  service_type;
        logic [7:0]  service_subtype;
        logic [7:0]  source_id;
        logic [15:0] crc_expected;
        logic [15:0] crc_computed;
        logic        crc_ok;
    } t_res;

    // CRC-16-CCITT over one byte, MSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] c;
        int          k;
        c = crc_in ^ {data, 8'h00};
        for (k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

>>> rtl/core/tcpc_byte_if.sv
// Byte stream channel
interface tcpc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

>>> rtl/core/tcpc_res_if.sv
// Decoded packet channel
interface tcpc_res_if;
    logic           valid;
    logic           ready;
    tcpc_pkg::t_res data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/tcpc_in_stage.sv
// Input register: holds one byte until the parser takes it
module tcpc_in_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    tcpc_byte_if.sink        i_rx,
    input  logic             i_take,
    output logic             o_valid,
    output logic [7:0]       o_byte
);
    logic       r_valid;
    logic [7:0] r_byte;

    // Free slot, or the held byte leaves this cycle
    assign i_rx.ready = !r_valid || i_take;
    assign o_valid    = r_valid;
    assign o_byte     = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_byte <= i_rx.rx_byte;
        end
    end
endmodule

>>> rtl/core/tcpc_parser.sv
`include "assert_macros.svh"

// Packet field assembly and running CRC, one byte per cycle while the result register has room
module tcpc_parser (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [7:0]      i_byte,
    input  logic            i_space,
    output logic            o_take,
    output logic            o_res_valid,
    output tcpc_pkg::t_res  o_res
);
    tcpc_pkg::t_phase r_phase, n_phase;
    logic [3:0]       r_hidx, n_hidx;
    logic [15:0]      r_crc, n_crc;
    logic [15:0]      r_ident, n_ident;
    logic [15:0]      r_seq, n_seq;
    logic [15:0]      r_len, n_len;
    logic [31:0]      r_dfh, n_dfh;
    logic [15:0]      r_rem, n_rem;
    logic [7:0]       r_pec_hi, n_pec_hi;

    logic [15:0] crc_next;
    logic [3:0]  hidx_eff;
    logic [15:0] rem_init;
    logic [15:0] pec_word;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= tcpc_pkg::PH_HEADER;
            r_hidx  <= '0;
            r_crc   <= tcpc_pkg::CRC_INIT;
        end else begin
            r_phase <= n_phase;
            r_hidx  <= n_hidx;
            r_crc   <= n_crc;
        end
    end

    // Field registers, fully rewritten by every packet
    always_ff @(posedge i_clk) begin
        r_ident  <= n_ident;
        r_seq    <= n_seq;
        r_len    <= n_len;
        r_dfh    <= n_dfh;
        r_rem    <= n_rem;
        r_pec_hi <= n_pec_hi;
    end

    assign crc_next = tcpc_pkg::crc_byte(r_crc, i_byte);
    assign hidx_eff = (r_hidx >= tcpc_pkg::HDR_BYTES) ? 4'd0 : r_hidx;
    assign rem_init = (r_len >= tcpc_pkg::LEN_OFFSET) ? (r_len - tcpc_pkg::LEN_OFFSET) : 16'd0;
    assign pec_word = {r_pec_hi, i_byte};

    // Next state per phase
    always_comb begin
        n_phase     = r_phase;
        n_hidx      = r_hidx;
        n_crc       = r_crc;
        n_ident     = r_ident;
        n_seq       = r_seq;
        n_len       = r_len;
        n_dfh       = r_dfh;
        n_rem       = r_rem;
        n_pec_hi    = r_pec_hi;
        o_take      = i_valid && i_space;
        o_res_valid = 1'b0;
        if (o_take) begin
            unique case (r_phase)
                tcpc_pkg::PH_HEADER: begin
                    n_crc = crc_next;
                    if (hidx_eff < tcpc_pkg::IDX_SEQ) begin
                        n_ident = {r_ident[7:0], i_byte};
                    end else if (hidx_eff < tcpc_pkg::IDX_LEN) begin
                        n_seq = {r_seq[7:0], i_byte};
                    end else if (hidx_eff < tcpc_pkg::IDX_DFH) begin
                        n_len = {r_len[7:0], i_byte};
                    end else begin
                        n_dfh = {r_dfh[23:0], i_byte};
                    end
                    if (hidx_eff == tcpc_pkg::HDR_LAST) begin
                        // length bytes are complete by now
                        n_hidx  = '0;
                        n_rem   = rem_init;
                        n_phase = (rem_init != 16'd0) ? tcpc_pkg::PH_DATA
                                                      : tcpc_pkg::PH_PEC_HI;
                    end else begin
                        n_hidx = hidx_eff + 4'd1;
                    end
                end
                tcpc_pkg::PH_DATA: begin
                    n_crc = crc_next;
                    n_rem = r_rem - 16'd1;
                    if (r_rem == 16'd1) begin
                        n_phase = tcpc_pkg::PH_PEC_HI;
                    end
                end
                tcpc_pkg::PH_PEC_HI: begin
                    n_pec_hi = i_byte;
                    n_phase  = tcpc_pkg::PH_PEC_LO;
                end
                tcpc_pkg::PH_PEC_LO: begin
                    // packet done: emit and re-arm
                    o_res_valid = 1'b1;
                    n_phase     = tcpc_pkg::PH_HEADER;
                    n_hidx      = '0;
                    n_crc       = tcpc_pkg::CRC_INIT;
                end
            endcase
        end
    end

    // Result fields
    always_comb begin
        o_res.packet_ident    = r_ident;
        o_res.app_id          = r_ident[10:0];
        o_res.seq_flags       = r_seq[15:14];
        o_res.seq_count       = r_seq[13:0];
        o_res.length_field    = r_len;
        o_res.ack_bits        = r_dfh[27:24];
        o_res.service_type    = r_dfh[23:16];
        o_res.service_subtype = r_dfh[15:8];
        o_res.source_id       = r_dfh[7:0];
        o_res.crc_expected    = pec_word;
        o_res.crc_computed    = r_crc;
        o_res.crc_ok          = (pec_word == r_crc);
    end

    `ASSERT_NEVER(a_hidx_range, r_hidx >= tcpc_pkg::HDR_BYTES, "header index out of range")
    `ASSERT_ALWAYS(a_rem_nonzero, (r_phase == tcpc_pkg::PH_DATA) |-> (r_rem != 16'd0), "data phase with no bytes left")
    `ASSERT_ALWAYS(a_hidx_idle, (r_phase != tcpc_pkg::PH_HEADER) |-> (r_hidx == 4'd0), "header index left set outside header")
    `ASSERT_ALWAYS(a_rearm, o_res_valid |=> (r_phase == tcpc_pkg::PH_HEADER && r_crc == tcpc_pkg::CRC_INIT), "no re-arm after result")
endmodule

>>> rtl/core/tcpc_out_stage.sv
// Result register toward the consumer
module tcpc_out_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_res_valid,
    input  tcpc_pkg::t_res i_res,
    output logic           o_space,
    tcpc_res_if.source     o_res
);
    logic           r_valid;
    tcpc_pkg::t_res r_res;

    // Room when empty or the held result transfers now
    assign o_space     = !r_valid || o_res.ready;
    assign o_res.valid = r_valid;
    assign o_res.data  = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_space) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_space && i_res_valid) begin
            r_res <= i_res;
        end
    end
endmodule

>>> rtl/core/telecommand_packet_parse_crc_check.sv
// Channel   Dir  Payload                       Transfer
// i_rx      in   rx_byte (8)                   valid & ready
// o_res     out  decoded packet (tcpc_pkg::t_res)  valid & ready
//
// One byte per cycle sustained while the result is not stalled; a byte waits in the input register,
// and its field update and CRC step happen on the way to the result register.
// A result is registered when the parser takes the last error control byte from the input register.
// Synchronous active-low reset returns the parser to the first header byte.
// A stalled result holds the parser; the input register keeps taking bytes
// until it is full.
module telecommand_packet_parse_crc_check (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tcpc_byte_if.sink   i_rx,
    tcpc_res_if.source  o_res
);
    logic           in_valid;
    logic [7:0]     in_byte;
    logic           take;
    logic           space;
    logic           res_valid;
    tcpc_pkg::t_res res;

    tcpc_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (i_rx),
        .i_take  (take),
        .o_valid (in_valid),
        .o_byte  (in_byte)
    );

    tcpc_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (in_valid),
        .i_byte      (in_byte),
        .i_space     (space),
        .o_take      (take),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    tcpc_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_space     (space),
        .o_res       (o_res)
    );
endmodule

>>> tb/tc_packet_check.sv
`timescale 1ns / 100ps

// Helpers shared by the stimulus and the packet check
package tcpc_tb_pkg;

    // CRC-16-CCITT, one data bit at a time, MSB first
    function automatic logic [15:0] crc16_ccitt_step(input logic [15:0] crc,
                                                     input logic [7:0]  b);
        logic [15:0] c;
        logic        fb;
        int          i;
        c = crc;
        for (i = 7; i >= 0; i--) begin
            fb = c[15] ^ b[i];
            c  = {c[14:0], 1'b0} ^ (fb ? tcpc_pkg::CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

endpackage

// Watches both channels, parses the byte stream on its own and checks
// every decoded packet against the oldest one it predicted.
module tc_packet_check (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_rx_valid,
    input  logic           i_rx_ready,
    input  logic [7:0]     i_rx_byte,
    input  logic           i_res_valid,
    input  logic           i_res_ready,
    input  tcpc_pkg::t_res i_res_data,
    output int             o_fail_count,
    output int             o_pending
);
    import tcpc_pkg::*;
    import tcpc_tb_pkg::*;

    // Parser state
    t_phase      parse_phase;
    logic [3:0]  hdr_pos;
    logic [15:0] ident_acc;
    logic [15:0] seqctl_acc;
    logic [15:0] length_acc;
    logic [31:0] dfh_acc;
    logic [15:0] app_left;
    logic [15:0] crc_run;
    logic [15:0] pec_acc;

    t_res packet_q[$];
    int   fail_cnt = 0;

    initial begin
        o_fail_count <= 0;
        o_pending    <= 0;
    end

    task automatic clear_parser();
        parse_phase = PH_HEADER;
        hdr_pos     = '0;
        ident_acc   = '0;
        seqctl_acc  = '0;
        length_acc  = '0;
        dfh_acc     = '0;
        app_left    = '0;
        crc_run     = CRC_INIT;
        pec_acc     = '0;
    endtask

    // Advance the parser by one byte; a complete packet is queued
    task automatic parse_byte(input logic [7:0] b);
        t_res pkt;
        case (parse_phase)
            PH_HEADER: begin
                crc_run = crc16_ccitt_step(crc_run, b);
                if (hdr_pos < IDX_SEQ) begin
                    ident_acc = {ident_acc[7:0], b};
                end else if (hdr_pos < IDX_LEN) begin
                    seqctl_acc = {seqctl_acc[7:0], b};
                end else if (hdr_pos < IDX_DFH) begin
                    length_acc = {length_acc[7:0], b};
                end else begin
                    dfh_acc = {dfh_acc[23:0], b};
                end
                if (hdr_pos == HDR_LAST) begin
                    hdr_pos  = '0;
                    // short length means no application bytes
                    app_left = (length_acc >= LEN_OFFSET) ? length_acc - LEN_OFFSET : 16'd0;
                    parse_phase = (app_left != 16'd0) ? PH_DATA : PH_PEC_HI;
                end else begin
                    hdr_pos = hdr_pos + 4'd1;
                end
            end
            PH_DATA: begin
                crc_run  = crc16_ccitt_step(crc_run, b);
                app_left = app_left - 16'd1;
                if (app_left == 16'd0) begin
                    parse_phase = PH_PEC_HI;
                end
            end
            PH_PEC_HI: begin
                pec_acc     = {b, 8'h00};
                parse_phase = PH_PEC_LO;
            end
            default: begin
                pec_acc[7:0]        = b;
                pkt.packet_ident    = ident_acc;
                pkt.app_id          = ident_acc[10:0];
                pkt.seq_flags       = seqctl_acc[15:14];
                pkt.seq_count       = seqctl_acc[13:0];
                pkt.length_field    = length_acc;
                pkt.ack_bits        = dfh_acc[27:24];
                pkt.service_type    = dfh_acc[23:16];
                pkt.service_subtype = dfh_acc[15:8];
                pkt.source_id       = dfh_acc[7:0];
                pkt.crc_expected    = pec_acc;
                pkt.crc_computed    = crc_run;
                pkt.crc_ok          = (pec_acc == crc_run);
                packet_q.push_back(pkt);
                // re-arm for the next packet
                clear_parser();
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (act_val !== exp_val) begin
            $error("%s: expected %0h, got %0h", name, exp_val, act_val);
            fail_cnt++;
        end
    endtask

    task automatic check_packet(input t_res got);
        t_res exp_pkt;
        if (packet_q.size() == 0) begin
            $error("decoded packet with none outstanding");
            fail_cnt++;
        end else begin
            exp_pkt = packet_q.pop_front();
            check_field("packet_ident", exp_pkt.packet_ident, got.packet_ident);
            check_field("app_id", exp_pkt.app_id, got.app_id);
            check_field("seq_flags", exp_pkt.seq_flags, got.seq_flags);
            check_field("seq_count", exp_pkt.seq_count, got.seq_count);
            check_field("length_field", exp_pkt.length_field, got.length_field);
            check_field("ack_bits", exp_pkt.ack_bits, got.ack_bits);
            check_field("service_type", exp_pkt.service_type, got.service_type);
            check_field("service_subtype", exp_pkt.service_subtype, got.service_subtype);
            check_field("source_id", exp_pkt.source_id, got.source_id);
            check_field("crc_expected", exp_pkt.crc_expected, got.crc_expected);
            check_field("crc_computed", exp_pkt.crc_computed, got.crc_computed);
            check_field("crc_ok", exp_pkt.crc_ok, got.crc_ok);
        end
    endtask

    // Result transfer is checked before the byte transfer of the same edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parser();
            packet_q.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                check_packet(i_res_data);
            end
            if (i_rx_valid && i_rx_ready) begin
                parse_byte(i_rx_byte);
            end
        end
        o_fail_count <= fail_cnt;
        o_pending    <= packet_q.size();
    end

endmodule

>>> tb/telecommand_packet_parse_crc_check_tb.sv
`timescale 1ns / 100ps

module telecommand_packet_parse_crc_check_tb;
    import tcpc_pkg::*;
    import tcpc_tb_pkg::*;

    localparam int LIMIT      = 5_000_000;
    localparam int HOLD_START = 300;
    localparam int HOLD_LEN   = 400;
    localparam int TAIL       = 8;
    localparam int RAND_BYTES = 900;

    typedef enum int {PEC_GOOD, PEC_FLIP, PEC_RANDOM} t_pec_kind;
    typedef enum int {SINK_OPEN, SINK_HALF, SINK_SPARSE} t_sink_mode;

    logic clk = 1'b0;
    logic rst_n;
    int   cycle_cnt = 0;
    int   fail_count;
    int   pending;
    int   burst_left = 0;
    int   bytes_sent = 0;

    tcpc_byte_if rx_if ();
    tcpc_res_if  res_if ();

    telecommand_packet_parse_crc_check i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_rx    (rx_if),
        .o_res   (res_if)
    );

    tc_packet_check u_packet_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_rx_valid   (rx_if.valid),
        .i_rx_ready   (rx_if.ready),
        .i_rx_byte    (rx_if.rx_byte),
        .i_res_valid  (res_if.valid),
        .i_res_ready  (res_if.ready),
        .i_res_data   (res_if.data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    // Watchdog
    initial begin
        wait (cycle_cnt >= LIMIT);
        $display("telecommand_packet_parse_crc_check_tb NOT OK");
        $finish;
    end

    // One byte transfer; bursts of random length with random gaps between them
    task automatic send_byte(input logic [7:0] b);
        int gap;
        int pick;
        if (burst_left == 0) begin
            pick = $urandom_range(0, 9);
            if (pick < 5) begin
                gap = 0;
            end else if (pick < 9) begin
                gap = $urandom_range(1, 4);
            end else begin
                gap = $urandom_range(5, 20);
            end
            if (gap > 0) begin
                rx_if.valid   <= 1'b0;
                rx_if.rx_byte <= 8'($urandom);
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 48);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do @(posedge clk); while (!rx_if.ready);
        burst_left--;
        bytes_sent++;
    endtask

    // Header, application bytes and error control word of one packet
    task automatic send_packet(input logic [15:0] ident, input logic [15:0] seqctl,
                               input logic [15:0] len, input logic [31:0] dfh,
                               input t_pec_kind pec_kind);
        logic [79:0] hdr;
        logic [15:0] crc;
        logic [15:0] pec;
        logic [7:0]  b;
        int          app_cnt;
        int          k;
        hdr = {ident, seqctl, len, dfh};
        crc = CRC_INIT;
        for (k = 0; k < 10; k++) begin
            b   = hdr[79 - 8 * k -: 8];
            crc = crc16_ccitt_step(crc, b);
            send_byte(b);
        end
        app_cnt = (len >= LEN_OFFSET) ? int'(len - LEN_OFFSET) : 0;
        for (k = 0; k < app_cnt; k++) begin
            b   = 8'($urandom);
            crc = crc16_ccitt_step(crc, b);
            send_byte(b);
        end
        case (pec_kind)
            PEC_GOOD: pec = crc;
            PEC_FLIP: pec = crc ^ (16'h0001 << $urandom_range(0, 15));
            default:  pec = 16'($urandom);
        endcase
        send_byte(pec[15:8]);
        send_byte(pec[7:0]);
    endtask

    // Result side: changing stall pattern, one long hold-off
    initial begin
        int         n;
        t_sink_mode mode;
        mode = SINK_OPEN;
        res_if.ready <= 1'b0;
        while (rst_n !== 1'b1) @(posedge clk);
        n = 0;
        forever begin
            if (n == HOLD_START) begin
                res_if.ready <= 1'b0;
                repeat (HOLD_LEN) @(posedge clk);
            end
            if (n % 64 == 0) begin
                mode = t_sink_mode'($urandom_range(0, 2));
            end
            case (mode)
                SINK_OPEN: res_if.ready <= 1'b1;
                SINK_HALF: res_if.ready <= 1'($urandom_range(0, 1));
                default:   res_if.ready <= ($urandom_range(0, 3) == 0);
            endcase
            @(posedge clk);
            n++;
        end
    end

    // Stimulus and verdict
    initial begin
        int        pick;
        logic [15:0] len;
        t_pec_kind kind;
        rst_n         <= 1'b0;
        rx_if.valid   <= 1'b0;
        rx_if.rx_byte <= 8'h00;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // all-ones fields with zero length, good CRC
        send_packet(16'hFFFF, 16'hFFFF, 16'h0000, 32'hFFFF_FFFF, PEC_GOOD);
        // all-zero fields, length at the offset (no application bytes), bad CRC
        send_packet(16'h0000, 16'h0000, LEN_OFFSET, 32'h0000_0000, PEC_FLIP);

        // random packets, mostly small and well formed
        while (bytes_sent < RAND_BYTES) begin
            pick = $urandom_range(0, 9);
            if (pick < 2) begin
                len = 16'($urandom_range(0, 4));
            end else if (pick < 9) begin
                len = 16'($urandom_range(5, 24));
            end else begin
                len = 16'($urandom_range(25, 80));
            end
            pick = $urandom_range(0, 9);
            kind = (pick < 7) ? PEC_GOOD : (pick < 9) ? PEC_FLIP : PEC_RANDOM;
            send_packet(16'($urandom), 16'($urandom), len, $urandom, kind);
        end

        rx_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (TAIL) @(posedge clk);
        if (fail_count == 0) begin
            $display("telecommand_packet_parse_crc_check_tb OK");
        end else begin
            $display("telecommand_packet_parse_crc_check_tb NOT OK");
        end
        $finish;
    end

endmodule
